/* hw/rtl/c3f_pkg.sv */
// ----------------------------------------------------------------------------
// c3f_pkg
// Shared constants, types and kernel tables of the 3x3 image filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package c3f_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int DIM_W      = 11;
	localparam int CMP_W      = DIM_W + 1;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
	localparam int POS_W      = 10;
	localparam int SMP_W      = 8;
	localparam int NUM_CH     = 3;
	localparam int KSEL_W     = 3;
	localparam int NUM_KERN   = 5;
	localparam int NUM_TAPS   = 9;
	localparam int TAP_IDX_W  = 4;
	localparam int COEF_W     = 5;
	localparam int SUM_W      = 13;
	localparam int MAG_W      = SUM_W - 1;
	localparam int REC_W      = 13;
	localparam int SHF_W      = 4;
	localparam int PROD_W     = MAG_W + REC_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DIM_W;

	localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd640;
	localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd480;
	localparam logic [SMP_W-1:0] SMP_MAX    = 8'd255;

	localparam logic [REC_W-1:0] REC_NINE  = 13'd3641;
	localparam logic [SHF_W-1:0] SHF_NINE  = 4'd15;
	localparam logic [REC_W-1:0] REC_THREE = 13'd5462;
	localparam logic [SHF_W-1:0] SHF_THREE = 4'd14;
	localparam logic [REC_W-1:0] REC_ONE   = 13'd1;
	localparam logic [SHF_W-1:0] SHF_SIXTN = 4'd4;
	localparam logic [SHF_W-1:0] SHF_NONE  = 4'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_KERNEL = 2'd2,
		REG_COLOR  = 2'd3
	} cfg_reg_t;

	typedef enum logic [KSEL_W-1:0] {
		K_SMOOTH  = 3'd0,
		K_BLUR    = 3'd1,
		K_SHARPEN = 3'd2,
		K_MEAN    = 3'd3,
		K_EMBOSS  = 3'd4
	} kern_t;

	typedef logic [SMP_W-1:0] smp_t;
	typedef smp_t [NUM_CH-1:0] rgb_t;
	typedef rgb_t [2:0] column_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} meta_t;

	typedef struct packed {
		smp_t  ch0;
		smp_t  ch1;
		smp_t  ch2;
		meta_t meta;
	} res_t;

	typedef struct packed {
		logic st_en;
		logic p_en;
		logic clr;
		logic zmask;
	} cell_ctl_t;

	typedef struct packed {
		logic [REC_W-1:0] rec;
		logic [SHF_W-1:0] sh;
	} scale_t;

	localparam logic signed [COEF_W-1:0] KCOEF [NUM_KERN][NUM_TAPS] = '{
		'{5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1},
		'{5'sd1, 5'sd2, 5'sd1, 5'sd2, 5'sd4, 5'sd2, 5'sd1, 5'sd2, 5'sd1},
		'{5'sd0, -5'sd2, 5'sd0, -5'sd2, 5'sd11, -5'sd2, 5'sd0, -5'sd2, 5'sd0},
		'{-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd9, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
		'{5'sd0, -5'sd1, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd0, 5'sd1, 5'sd0}
	};

	function automatic kern_t ksan(input logic [KSEL_W-1:0] raw);
		if (raw > KSEL_W'(K_EMBOSS))
			return K_SMOOTH;
		else
			return kern_t'(raw);
	endfunction

	function automatic logic signed [COEF_W-1:0] kcoef(input kern_t k,
		input logic [TAP_IDX_W-1:0] idx);
		return KCOEF[k][idx];
	endfunction

	// floor division by the kernel denominator as reciprocal multiply and shift
	function automatic scale_t kscale(input kern_t k);
		scale_t s;
		case (k)
			K_SMOOTH:  s = '{rec: REC_NINE, sh: SHF_NINE};
			K_BLUR:    s = '{rec: REC_ONE, sh: SHF_SIXTN};
			K_SHARPEN: s = '{rec: REC_THREE, sh: SHF_THREE};
			default:   s = '{rec: REC_ONE, sh: SHF_NONE};
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/c3f_ifs.sv */
// ----------------------------------------------------------------------------
// c3f channel interfaces
// Pixel input, filtered result output and register write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface c3f_pix_if;
	logic          valid;
	logic          ready;
	c3f_pkg::smp_t chan_zero;
	c3f_pkg::smp_t chan_one;
	c3f_pkg::smp_t chan_two;
	logic          is_flush;

	modport source (output valid, chan_zero, chan_one, chan_two, is_flush, input ready);
	modport sink (input valid, chan_zero, chan_one, chan_two, is_flush, output ready);
endinterface

interface c3f_res_if;
	logic                      valid;
	logic                      ready;
	c3f_pkg::smp_t             out_chan_zero;
	c3f_pkg::smp_t             out_chan_one;
	c3f_pkg::smp_t             out_chan_two;
	logic [c3f_pkg::POS_W-1:0] out_row;
	logic [c3f_pkg::POS_W-1:0] out_col;
	logic                      last_of_frame;

	modport source (output valid, out_chan_zero, out_chan_one, out_chan_two, out_row,
		out_col, last_of_frame, input ready);
	modport sink (input valid, out_chan_zero, out_chan_one, out_chan_two, out_row,
		out_col, last_of_frame, output ready);
endinterface

interface c3f_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [c3f_pkg::CFG_IDX_W-1:0]  index;
	logic [c3f_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/c3f_line_buf.sv */
// ----------------------------------------------------------------------------
// c3f_line_buf
// Two line stores of one row each, zeroed by a sweep after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c3f_line_buf (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      acc,
	input  logic                      adv,
	input  logic [c3f_pkg::COL_W-1:0] addr,
	input  c3f_pkg::rgb_t             wdata,
	output c3f_pkg::rgb_t             top_s1,
	output c3f_pkg::rgb_t             mid_s1,
	output logic                      run
);

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} lb_state_t;

	lb_state_t                 state_q;
	logic [c3f_pkg::COL_W-1:0] clr_cnt_q;
	logic                      pend_q;
	logic [c3f_pkg::COL_W-1:0] pend_addr_q;
	logic                      clearing;
	logic                      fwd;

	c3f_pkg::rgb_t mem_up  [c3f_pkg::MAX_WIDTH];
	c3f_pkg::rgb_t mem_mid [c3f_pkg::MAX_WIDTH];

	assign clearing = (state_q == ST_CLEAR);
	assign run      = (state_q == ST_RUN);
	assign fwd      = pend_q && (pend_addr_q == addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + c3f_pkg::COL_W'(1);
					if (clr_cnt_q == c3f_pkg::COL_W'(c3f_pkg::MAX_WIDTH - 1))
						state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (adv)
						pend_q <= acc;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			pend_addr_q <= addr;
	end

	// middle row is written at the transaction, upper row from mid_s1 when pend_q is set and adv is high
	always_ff @(posedge clk) begin
		if (clearing) begin
			mem_mid[clr_cnt_q] <= '0;
			mem_up[clr_cnt_q]  <= '0;
		end else begin
			if (acc) begin
				mem_mid[addr] <= wdata;
				mid_s1        <= mem_mid[addr];
				top_s1        <= fwd ? mid_s1 : mem_up[addr];
			end
			if (adv && pend_q)
				mem_up[pend_addr_q] <= mid_s1;
		end
	end

endmodule

/* hw/rtl/c3f_col_cell.sv */
// ----------------------------------------------------------------------------
// c3f_col_cell
// One window column: holds three taps, passes them on, forms its partial sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c3f_col_cell (
	input  logic               clk,
	input  c3f_pkg::cell_ctl_t ctl,
	input  c3f_pkg::kern_t     kern,
	input  logic [1:0]         col_idx,
	input  c3f_pkg::column_t   din,
	output c3f_pkg::column_t   dout,
	output c3f_pkg::sum_t      part_s2 [c3f_pkg::NUM_CH]
);

	c3f_pkg::column_t col_q;
	c3f_pkg::sum_t    part_d [c3f_pkg::NUM_CH];

	assign dout = col_q;

	always_comb begin
		c3f_pkg::sum_t                     tap;
		c3f_pkg::sum_t                     coef;
		logic signed [c3f_pkg::COEF_W-1:0] craw;
		logic [c3f_pkg::TAP_IDX_W-1:0]     idx;
		for (int c = 0; c < c3f_pkg::NUM_CH; c++) begin
			part_d[c] = '0;
			for (int r = 0; r < 3; r++) begin
				idx  = c3f_pkg::TAP_IDX_W'(3 * r) + c3f_pkg::TAP_IDX_W'(col_idx);
				craw = c3f_pkg::kcoef(kern, idx);
				coef = {{(c3f_pkg::SUM_W - c3f_pkg::COEF_W){craw[c3f_pkg::COEF_W-1]}}, craw};
				if (ctl.zmask)
					tap = '0;
				else
					tap = {{(c3f_pkg::SUM_W - c3f_pkg::SMP_W){1'b0}}, din[r][c]};
				part_d[c] = part_d[c] + tap * coef;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.st_en)
			col_q <= ctl.clr ? '0 : din;
		if (ctl.p_en) begin
			for (int c = 0; c < c3f_pkg::NUM_CH; c++)
				part_s2[c] <= part_d[c];
		end
	end

endmodule

/* hw/rtl/c3f_scale.sv */
// ----------------------------------------------------------------------------
// c3f_scale
// Column sum, clamp at zero, division by the kernel denominator, clamp at 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c3f_scale (
	input  logic           clk,
	input  logic           en,
	input  c3f_pkg::kern_t kern,
	input  c3f_pkg::sum_t  part_a,
	input  c3f_pkg::sum_t  part_b,
	input  c3f_pkg::sum_t  part_c,
	output c3f_pkg::smp_t  q
);

	c3f_pkg::sum_t              sum_s3;
	c3f_pkg::scale_t            sc;
	logic [c3f_pkg::MAG_W-1:0]  mag;
	logic [c3f_pkg::PROD_W-1:0] prod;
	logic [c3f_pkg::PROD_W-1:0] quo;

	always_ff @(posedge clk) begin
		if (en)
			sum_s3 <= part_a + part_b + part_c;
	end

	always_comb begin
		sc   = c3f_pkg::kscale(kern);
		mag  = sum_s3[c3f_pkg::MAG_W-1:0];
		prod = c3f_pkg::PROD_W'(mag) * c3f_pkg::PROD_W'(sc.rec);
		quo  = prod >> sc.sh;
		if (sum_s3[c3f_pkg::SUM_W-1])
			q = '0;
		else if (quo > c3f_pkg::PROD_W'(c3f_pkg::SMP_MAX))
			q = c3f_pkg::SMP_MAX;
		else
			q = quo[c3f_pkg::SMP_W-1:0];
	end

endmodule

/* hw/rtl/conv3x3_image_filter.sv */
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// Throughput: one pixel transaction per cycle while the skid entry is empty,
// set by one line store access per column and a three-cell window that shifts
// once per transaction. A result passes registers s1, s2, s3 and the output
// register after the transaction that completes its window, W+1 transactions
// after its own pixel. Reset: registers take defaults; the line stores are
// zeroed over all MAX_WIDTH (1024) addresses, pixel ready stays low meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module conv3x3_image_filter (
	input logic        clk,
	input logic        arst_n,
	c3f_pix_if.sink    pixel,
	c3f_res_if.source  result,
	c3f_cfg_if.sink    cfg
);

	logic [c3f_pkg::DIM_W-1:0]  width_q;
	logic [c3f_pkg::DIM_W-1:0]  height_q;
	logic [c3f_pkg::KSEL_W-1:0] ksel_q;
	logic                       color_q;
	c3f_pkg::kern_t             kern;

	logic [c3f_pkg::DIM_W-1:0] w_eff;
	logic [c3f_pkg::DIM_W-1:0] h_eff;
	logic [c3f_pkg::CMP_W-1:0] wx;
	logic [c3f_pkg::CMP_W-1:0] hx;
	logic [c3f_pkg::CMP_W-1:0] icx;
	logic [c3f_pkg::CMP_W-1:0] irx;
	logic [c3f_pkg::CMP_W-1:0] cx;
	logic [c3f_pkg::CMP_W-1:0] rx;
	logic [c3f_pkg::CMP_W-1:0] ic_inc;
	logic [c3f_pkg::CMP_W-1:0] row_full;
	logic [c3f_pkg::CMP_W-1:0] col_full;
	logic                      restart;
	logic                      at_end;
	logic                      wrap;
	logic                      drain;
	logic                      em_edge;
	logic                      em_main;

	logic [c3f_pkg::COL_W-1:0] ic_q;
	logic [c3f_pkg::COL_W-1:0] ic_cur;
	logic [c3f_pkg::ROW_W-1:0] ir_q;
	logic [c3f_pkg::ROW_W-1:0] ir_cur;

	logic adv;
	logic acc;
	logic lb_run;

	c3f_pkg::rgb_t  smp_in;
	c3f_pkg::rgb_t  top_s1;
	c3f_pkg::rgb_t  mid_s1;
	c3f_pkg::rgb_t  smp_s1;
	c3f_pkg::meta_t meta_in;
	c3f_pkg::meta_t meta_s1;
	c3f_pkg::meta_t meta_s2;
	c3f_pkg::meta_t meta_s3;
	logic           v_s1;
	logic           v_s2;
	logic           v_s3;
	logic           emit_s1;
	logic           first_s1;
	logic           top_ok_s1;
	logic           mid_ok_s1;

	c3f_pkg::column_t   col_new;
	c3f_pkg::column_t   dout0;
	c3f_pkg::column_t   dout1;
	c3f_pkg::column_t   dout2;
	c3f_pkg::cell_ctl_t ctl_old;
	c3f_pkg::cell_ctl_t ctl_new;
	c3f_pkg::sum_t      part0 [c3f_pkg::NUM_CH];
	c3f_pkg::sum_t      part1 [c3f_pkg::NUM_CH];
	c3f_pkg::sum_t      part2 [c3f_pkg::NUM_CH];
	c3f_pkg::smp_t      q_ch  [c3f_pkg::NUM_CH];

	c3f_pkg::res_t out_q;
	c3f_pkg::res_t skid_q;
	c3f_pkg::res_t res_new;
	logic          out_v_q;
	logic          skid_v_q;
	logic          take;
	logic          push;

	// register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= c3f_pkg::RST_WIDTH;
			height_q <= c3f_pkg::RST_HEIGHT;
			ksel_q   <= c3f_pkg::KSEL_W'(c3f_pkg::K_SMOOTH);
			color_q  <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				c3f_pkg::REG_WIDTH:  width_q  <= cfg.data;
				c3f_pkg::REG_HEIGHT: height_q <= cfg.data;
				c3f_pkg::REG_KERNEL: ksel_q   <= cfg.data[c3f_pkg::KSEL_W-1:0];
				c3f_pkg::REG_COLOR:  color_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign kern = c3f_pkg::ksan(ksel_q);

	// raster position
	always_comb begin
		if (width_q == '0)
			w_eff = c3f_pkg::DIM_W'(1);
		else if (width_q > c3f_pkg::DIM_W'(c3f_pkg::MAX_WIDTH))
			w_eff = c3f_pkg::DIM_W'(c3f_pkg::MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q == '0)
			h_eff = c3f_pkg::DIM_W'(1);
		else if (height_q > c3f_pkg::DIM_W'(c3f_pkg::MAX_HEIGHT))
			h_eff = c3f_pkg::DIM_W'(c3f_pkg::MAX_HEIGHT);
		else
			h_eff = height_q;

		wx  = c3f_pkg::CMP_W'(w_eff);
		hx  = c3f_pkg::CMP_W'(h_eff);
		icx = c3f_pkg::CMP_W'(ic_q);
		irx = c3f_pkg::CMP_W'(ir_q);

		restart = (icx >= wx) || (irx > hx + c3f_pkg::CMP_W'(1)) ||
			((irx == hx + c3f_pkg::CMP_W'(1)) && (icx != '0));
		ic_cur = restart ? '0 : ic_q;
		ir_cur = restart ? '0 : ir_q;
		cx     = c3f_pkg::CMP_W'(ic_cur);
		rx     = c3f_pkg::CMP_W'(ir_cur);

		at_end = (rx == hx + c3f_pkg::CMP_W'(1));
		ic_inc = cx + c3f_pkg::CMP_W'(1);
		wrap   = (ic_inc == wx);
		drain  = (rx >= hx);

		em_edge = (cx == '0) && (rx >= c3f_pkg::CMP_W'(2));
		em_main = (cx != '0) && (rx >= c3f_pkg::CMP_W'(1)) && (rx <= hx);

		row_full = em_edge ? rx - c3f_pkg::CMP_W'(2) : rx - c3f_pkg::CMP_W'(1);
		col_full = em_edge ? wx - c3f_pkg::CMP_W'(1) : cx - c3f_pkg::CMP_W'(1);

		meta_in.row  = row_full[c3f_pkg::POS_W-1:0];
		meta_in.col  = col_full[c3f_pkg::POS_W-1:0];
		meta_in.last = (row_full == hx - c3f_pkg::CMP_W'(1)) &&
			(col_full == wx - c3f_pkg::CMP_W'(1));

		if (pixel.is_flush || drain)
			smp_in = '0;
		else begin
			smp_in[0] = pixel.chan_zero;
			smp_in[1] = pixel.chan_one;
			smp_in[2] = pixel.chan_two;
		end
	end

	assign adv         = !skid_v_q;
	assign pixel.ready = lb_run && adv;
	assign acc         = pixel.valid && pixel.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ic_q <= '0;
			ir_q <= '0;
		end else if (acc) begin
			if (at_end) begin
				ic_q <= '0;
				ir_q <= '0;
			end else if (wrap) begin
				ic_q <= '0;
				ir_q <= c3f_pkg::ROW_W'(rx + c3f_pkg::CMP_W'(1));
			end else begin
				ic_q <= ic_inc[c3f_pkg::COL_W-1:0];
				ir_q <= ir_cur;
			end
		end
	end

	c3f_line_buf u_line_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.adv    (adv),
		.addr   (ic_cur),
		.wdata  (smp_in),
		.top_s1 (top_s1),
		.mid_s1 (mid_s1),
		.run    (lb_run)
	);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			smp_s1    <= smp_in;
			meta_s1   <= meta_in;
			emit_s1   <= em_edge || em_main;
			first_s1  <= (cx == '0);
			top_ok_s1 <= (rx >= c3f_pkg::CMP_W'(2));
			mid_ok_s1 <= (rx >= c3f_pkg::CMP_W'(1)) && (rx <= hx);
		end
		if (adv) begin
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
		end
	end

	// window cells, newest column enters at cell two
	assign col_new[0] = top_ok_s1 ? top_s1 : '0;
	assign col_new[1] = mid_ok_s1 ? mid_s1 : '0;
	assign col_new[2] = smp_s1;

	assign ctl_old = '{st_en: adv && v_s1, p_en: adv, clr: first_s1, zmask: 1'b0};
	assign ctl_new = '{st_en: adv && v_s1, p_en: adv, clr: 1'b0, zmask: first_s1};

	c3f_col_cell u_cell0 (
		.clk     (clk),
		.ctl     (ctl_old),
		.kern    (kern),
		.col_idx (2'd0),
		.din     (dout1),
		.dout    (dout0),
		.part_s2 (part0)
	);

	c3f_col_cell u_cell1 (
		.clk     (clk),
		.ctl     (ctl_old),
		.kern    (kern),
		.col_idx (2'd1),
		.din     (dout2),
		.dout    (dout1),
		.part_s2 (part1)
	);

	c3f_col_cell u_cell2 (
		.clk     (clk),
		.ctl     (ctl_new),
		.kern    (kern),
		.col_idx (2'd2),
		.din     (col_new),
		.dout    (dout2),
		.part_s2 (part2)
	);

	for (genvar g = 0; g < c3f_pkg::NUM_CH; g++) begin : g_chan
		c3f_scale u_scale (
			.clk    (clk),
			.en     (adv),
			.kern   (kern),
			.part_a (part0[g]),
			.part_b (part1[g]),
			.part_c (part2[g]),
			.q      (q_ch[g])
		);
	end

	// output register with skid entry
	always_comb begin
		res_new.ch0  = q_ch[0];
		res_new.ch1  = color_q ? q_ch[1] : '0;
		res_new.ch2  = color_q ? q_ch[2] : '0;
		res_new.meta = meta_s3;
	end

	assign take = out_v_q && result.ready;
	assign push = adv && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take)
				skid_v_q <= 1'b0;
		end else if (push) begin
			if (!out_v_q || take)
				out_v_q <= 1'b1;
			else
				skid_v_q <= 1'b1;
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take)
				out_q <= skid_q;
		end else if (push) begin
			if (!out_v_q || take)
				out_q <= res_new;
			else
				skid_q <= res_new;
		end
	end

	assign result.valid         = out_v_q;
	assign result.out_chan_zero = out_q.ch0;
	assign result.out_chan_one  = out_q.ch1;
	assign result.out_chan_two  = out_q.ch2;
	assign result.out_row       = out_q.meta.row;
	assign result.out_col       = out_q.meta.col;
	assign result.last_of_frame = out_q.meta.last;

endmodule

/* sim/conv3x3_image_filter_tb.sv */
// ----------------------------------------------------------------------------
// conv3x3_image_filter_tb
// Streams raster frames through the 3x3 filter under several sizes, kernels
// and color modes, predicts each filtered pixel in a line-store and window
// model of its own, and checks every result transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module conv3x3_image_filter_tb;

	import c3f_pkg::*;

	localparam int SETTLE_CYCLES = 16;

	localparam int TAPS [NUM_KERN][NUM_TAPS] = '{
		'{1, 1, 1, 1, 1, 1, 1, 1, 1},
		'{1, 2, 1, 2, 4, 2, 1, 2, 1},
		'{0, -2, 0, -2, 11, -2, 0, -2, 0},
		'{-1, -1, -1, -1, 9, -1, -1, -1, -1},
		'{0, -1, 0, 0, 0, 0, 0, 1, 0}
	};
	localparam int DIVISOR [NUM_KERN] = '{9, 16, 3, 1, 1};

	logic clk;
	logic arst_n;

	c3f_pix_if pixel ();
	c3f_res_if result ();
	c3f_cfg_if cfg ();

	conv3x3_image_filter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.result (result),
		.cfg    (cfg)
	);

	// predicted filter state
	logic [DIM_W-1:0]  cfg_width;
	logic [DIM_W-1:0]  cfg_height;
	logic [KSEL_W-1:0] cfg_kernel;
	logic              cfg_color;
	rgb_t              line_upper [MAX_WIDTH];
	rgb_t              line_middle [MAX_WIDTH];
	rgb_t              win [NUM_TAPS];
	int unsigned       pos_col;
	int unsigned       pos_row;

	res_t filtered_due [$];

	int error_count   = 0;
	int items_sent    = 0;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_req      = 0;
	int hold_left     = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int unsigned frame_w();
		int unsigned w;
		w = (cfg_width == 0) ? 1 : cfg_width;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned frame_h();
		int unsigned h;
		h = (cfg_height == 0) ? 1 : cfg_height;
		if (h > MAX_HEIGHT)
			h = MAX_HEIGHT;
		return h;
	endfunction

	function automatic void filter_reset();
		cfg_width  = RST_WIDTH;
		cfg_height = RST_HEIGHT;
		cfg_kernel = K_SMOOTH;
		cfg_color  = 1'b1;
		foreach (line_upper[i]) begin
			line_upper[i]  = '0;
			line_middle[i] = '0;
		end
		foreach (win[i])
			win[i] = '0;
		pos_col = 0;
		pos_row = 0;
	endfunction

	function automatic void apply_config(cfg_reg_t idx, logic [DIM_W-1:0] data);
		case (idx)
			REG_WIDTH:  cfg_width = data;
			REG_HEIGHT: cfg_height = data;
			REG_KERNEL: cfg_kernel = data[KSEL_W-1:0];
			REG_COLOR:  cfg_color = data[0];
		endcase
	endfunction

	function automatic void shift_window(rgb_t top, rgb_t mid, rgb_t bot);
		rgb_t col [3];
		col[0] = top;
		col[1] = mid;
		col[2] = bot;
		for (int r = 0; r < 3; r++) begin
			win[r * 3]     = win[r * 3 + 1];
			win[r * 3 + 1] = win[r * 3 + 2];
			win[r * 3 + 2] = col[r];
		end
	endfunction

	function automatic smp_t kernel_sum(kern_t k, int ch);
		int acc;
		acc = 0;
		for (int i = 0; i < NUM_TAPS; i++)
			acc += TAPS[int'(k)][i] * int'(win[i][ch]);
		if (acc < 0)
			return '0;
		acc = acc / DIVISOR[int'(k)];
		return (acc > 255) ? SMP_MAX : smp_t'(acc);
	endfunction

	function automatic res_t filtered_at(int unsigned row, int unsigned col,
		int unsigned w, int unsigned h);
		res_t r;
		kern_t k;
		k = (cfg_kernel > K_EMBOSS) ? K_SMOOTH : kern_t'(cfg_kernel);
		r.ch0 = kernel_sum(k, 0);
		r.ch1 = cfg_color ? kernel_sum(k, 1) : '0;
		r.ch2 = cfg_color ? kernel_sum(k, 2) : '0;
		r.meta.row = POS_W'(row);
		r.meta.col = POS_W'(col);
		r.meta.last = (row == h - 1 && col == w - 1);
		return r;
	endfunction

	// one accepted pixel transaction through the predicted filter
	function automatic void filter_pixel_step(smp_t c0, smp_t c1, smp_t c2, logic flush);
		int unsigned w, h, ic, ir;
		rgb_t smp, top, mid;
		w = frame_w();
		h = frame_h();
		if (pos_col >= w || pos_row > h + 1 || (pos_row == h + 1 && pos_col != 0)) begin
			pos_col = 0;
			pos_row = 0;
		end
		ic = pos_col;
		ir = pos_row;
		smp = (flush || ir >= h) ? rgb_t'(0) : rgb_t'({c2, c1, c0});
		if (ic == 0) begin
			// right edge of the row two above
			shift_window('0, '0, '0);
			if (ir >= 2)
				filtered_due.push_back(filtered_at(ir - 2, w - 1, w, h));
			foreach (win[i])
				win[i] = '0;
		end
		top = (ir >= 2 && ir - 2 < h) ? line_upper[ic] : rgb_t'(0);
		mid = (ir >= 1 && ir - 1 < h) ? line_middle[ic] : rgb_t'(0);
		shift_window(top, mid, smp);
		line_upper[ic]  = line_middle[ic];
		line_middle[ic] = smp;
		if (ic >= 1 && ir >= 1 && ir <= h)
			filtered_due.push_back(filtered_at(ir - 1, ic - 1, w, h));
		if (ir == h + 1) begin
			pos_row = 0;
			pos_col = 0;
		end else begin
			pos_col = ic + 1;
			if (pos_col == w) begin
				pos_col = 0;
				pos_row = ir + 1;
			end
		end
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	// receiver with random stalls and long hold-offs on request
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && result.valid === 1'b1 && result.ready === 1'b1) begin
			if (filtered_due.size() == 0) begin
				$error("result transaction row %0d col %0d with nothing expected",
					result.out_row, result.out_col);
				error_count++;
			end else begin
				want = filtered_due.pop_front();
				check_field("out_chan_zero", 16'(want.ch0), 16'(result.out_chan_zero));
				check_field("out_chan_one", 16'(want.ch1), 16'(result.out_chan_one));
				check_field("out_chan_two", 16'(want.ch2), 16'(result.out_chan_two));
				check_field("out_row", 16'(want.meta.row), 16'(result.out_row));
				check_field("out_col", 16'(want.meta.col), 16'(result.out_col));
				check_field("last_of_frame", 16'(want.meta.last),
					16'(result.last_of_frame));
			end
		end
	end

	task automatic send_pixel(smp_t c0, smp_t c1, smp_t c2, logic flush);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			pixel.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct);
		end
		pixel.valid     <= 1'b1;
		pixel.chan_zero <= c0;
		pixel.chan_one  <= c1;
		pixel.chan_two  <= c2;
		pixel.is_flush  <= flush;
		@(posedge clk);
		while (!pixel.ready)
			@(posedge clk);
		filter_pixel_step(c0, c1, c2, flush);
		items_sent++;
	endtask

	task automatic send_random(int flush_pct);
		send_pixel(smp_t'($urandom), smp_t'($urandom), smp_t'($urandom),
			$urandom_range(0, 99) < flush_pct);
	endtask

	// wait until every predicted result has come and the pipeline is empty
	task automatic quiesce();
		pixel.valid <= 1'b0;
		@(posedge clk);
		while (filtered_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [DIM_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		apply_config(idx, data);
	endtask

	task automatic set_config(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
		logic [DIM_W-1:0] k, logic [DIM_W-1:0] c);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_KERNEL, k);
		write_reg(REG_COLOR, c);
		cfg.valid <= 1'b0;
	endtask

	// full frame plus drain; pause_at waits for all results after that many pixels
	task automatic send_frame(int flush_pct, int drain_pix_pct, int pause_at);
		int npix;
		int ndrain;
		npix   = frame_w() * frame_h();
		ndrain = frame_w() + 1;
		for (int i = 0; i < npix; i++) begin
			if (pause_at != 0 && i == pause_at)
				quiesce();
			send_random(flush_pct);
		end
		repeat (ndrain)
			send_pixel(smp_t'($urandom), smp_t'($urandom), smp_t'($urandom),
				$urandom_range(0, 99) >= drain_pix_pct);
	endtask

	task automatic test_kernels();
		smp_t hi;
		send_idle_pct = 13;
		stall_pct = 13;
		// the codes above emboss fall back to smooth
		for (int k = 0; k < 2 ** KSEL_W; k++) begin
			quiesce();
			set_config(2, 2, DIM_W'(k), 1);
			for (int p = 0; p < 4; p++) begin
				hi = (p == 0 || p == 3) ? SMP_MAX : smp_t'(0);
				send_pixel(hi, SMP_MAX, ~hi, 1'b0);
			end
			repeat (frame_w() + 1)
				send_pixel(SMP_MAX, '0, SMP_MAX, 1'b1);
		end
	endtask

	task automatic test_grayscale();
		quiesce();
		set_config(3, 3, K_BLUR, 0);
		send_frame(0, 0, 0);
		quiesce();
		set_config(4, 2, K_SHARPEN, 0);
		send_frame(0, 0, 0);
	endtask

	task automatic test_flush_and_drain();
		quiesce();
		set_config(4, 3, K_MEAN, 1);
		send_frame(30, 50, 0);
		// frames back to back, position wraps after the last pixel
		send_frame(0, 0, 0);
		send_frame(0, 100, 0);
	endtask

	task automatic test_resize_mid_frame();
		quiesce();
		set_config(6, 4, K_SHARPEN, 1);
		repeat (14) send_random(0);
		quiesce();
		set_config(4, 4, K_SHARPEN, 1);
		repeat (8) send_random(0);
		// column past the new width
		quiesce();
		set_config(2, 4, K_SHARPEN, 1);
		send_frame(0, 0, 0);
		quiesce();
		set_config(3, 6, K_BLUR, 1);
		repeat (17) send_random(0);
		// drain row with a nonzero column
		quiesce();
		set_config(3, 4, K_BLUR, 1);
		send_frame(0, 0, 0);
		quiesce();
		set_config(3, 6, K_EMBOSS, 1);
		repeat (15) send_random(0);
		// row past the new frame and drain
		quiesce();
		set_config(3, 2, K_EMBOSS, 1);
		send_frame(0, 0, 0);
	endtask

	task automatic test_size_limits();
		send_idle_pct = 0;
		stall_pct = 0;
		quiesce();
		set_config('0, '0, K_SHARPEN, 1);
		send_frame(0, 0, 0);
		// sizes above the limit, one full row and the start of the next
		quiesce();
		set_config('1, '1, K_BLUR, 1);
		repeat (MAX_WIDTH + 3) send_random(0);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		quiesce();
		set_config(8, 4, K_SHARPEN, 1);
		hold_req = 400;
		send_frame(0, 0, 0);
		send_idle_pct = 13;
		stall_pct = 13;
		send_frame(0, 0, 20);
	endtask

	task automatic random_phase(int idle_pct, int stall, int n_items);
		int stop_at;
		int kind;
		logic [DIM_W-1:0] w, h, kdata, cdata;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			quiesce();
			w = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 40)) :
				DIM_W'($urandom_range(1, 10));
			h = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 12)) :
				DIM_W'($urandom_range(1, 6));
			kdata = DIM_W'($urandom_range(0, 7));
			if ($urandom_range(0, 3) == 0)
				kdata |= DIM_W'($urandom) & ~DIM_W'(7);
			cdata = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom) :
				DIM_W'($urandom_range(0, 1));
			set_config(w, h, kdata, cdata);
			repeat ($urandom_range(1, 3)) begin
				kind = $urandom_range(0, 9);
				if (kind < 7)
					send_frame(kind == 0 ? 20 : 0, kind == 1 ? 40 : 0, 0);
				else if (kind < 9)
					repeat ($urandom_range(1, frame_w() * frame_h() + frame_w()))
						send_random(10);
				else
					repeat ($urandom_range(1, 20))
						send_random(50);
			end
		end
	endtask

	task automatic test_random_traffic();
		random_phase(0, 0, 20);
		random_phase(47, 0, 20);
		random_phase(0, 47, 20);
		random_phase(13, 13, 20);
	endtask

	initial begin
		arst_n          = 1'b0;
		pixel.valid     = 1'b0;
		pixel.chan_zero = '0;
		pixel.chan_one  = '0;
		pixel.chan_two  = '0;
		pixel.is_flush  = 1'b0;
		result.ready    = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = REG_WIDTH;
		cfg.data        = '0;
		filter_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_kernels();
		test_grayscale();
		test_flush_and_drain();
		test_resize_mid_frame();
		test_size_limits();
		test_backpressure();
		test_random_traffic();

		quiesce();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/c3f_pkg.sv
hw/rtl/c3f_ifs.sv
hw/rtl/c3f_line_buf.sv
hw/rtl/c3f_col_cell.sv
hw/rtl/c3f_scale.sv
hw/rtl/conv3x3_image_filter.sv
sim/conv3x3_image_filter_tb.sv
